// ===== rtl/core/tpc_pkg.sv =====
// Package for the timestamp pose cache: sizes, payload structs, cell types.
`timescale 1ns / 1ps
package tpc_pkg;
  localparam int DEPTH = 256;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int STAMP_W = 63;
  localparam int WIN_W = 42;
  localparam int GAP_W = 30;
  localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = {STAMP_W{1'b1}};
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(64'd30000000000);
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(32'd50000000);
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [0:0] REG_GAP = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z;
  } pose_t;

  typedef struct packed {
    logic command;
    logic [STAMP_W-1:0] stamp_ns;
    pose_t pose;
  } in_req_t;

  typedef struct packed {
    logic found;
    pose_t pose;
    logic [STAMP_W-1:0] time_gap_ns;
    logic [CNT_W-1:0] entries_held;
  } out_req_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    pose_t pose;
  } entry_t;

  // Per-cycle operation broadcast to every cell.
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SHIFT_DOWN = 2'd2;
  localparam logic [1:0] OP_REPLACE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0] count;
    entry_t entry;
  } cell_ctl_t;
endpackage

// ===== rtl/core/timestamp_pose_cache_nearest_match.sv =====
// Top level of the timestamp pose cache with nearest-stamp lookup.
// The cache is a row of DEPTH cells kept in ascending stamp order; every cell
// compares its stamp to one broadcast stamp each cycle, so the insert slot or
// the lookup neighbor is found in one pass and an insert shifts the row up by
// one cell at once. An insert runs S_FULL, S_INS and S_PRUNE, which repeats
// once per entry pruned (dropping the oldest entry of a full cache adds no
// step); a lookup runs find, read upper neighbor, read lower neighbor; an
// insert with a zero stamp answers the cycle after it is taken. The result
// then waits in an output register, and the next request is taken the cycle
// after the result leaves. One request is in work at a time. No clearing pass
// is needed after reset: only the first entries_held cells are ever read.
`timescale 1ns / 1ps
module timestamp_pose_cache_nearest_match import tpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_req_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output out_req_t     out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_FULL = 3'd1, S_INS = 3'd2,
                         S_PRUNE = 3'd3, S_LK = 3'd4, S_LK2 = 3'd5, S_OUT = 3'd6,
                         S_LK3 = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] count_r, rd_idx_r, n_below, best_r;
  logic [WIN_W-1:0] win_r;
  logic [GAP_W-1:0] gap_r;
  in_req_t req_r;
  out_req_t out_r;
  logic any_equal;
  entry_t rd_entry;
  cell_ctl_t ctl;
  logic [STAMP_W-1:0] bound;
  logic have_up_r;
  // lookup neighbors: upper one registered, lower one straight off the read port
  entry_t up_ent_r;
  logic [STAMP_W-1:0] d_up, d_lo, lk_gap;
  pose_t lk_pose;
  logic use_lo;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = out_r;

  // prune bound clamped at zero
  assign bound = (req_r.stamp_ns <= STAMP_W'(win_r)) ? '0 : req_r.stamp_ns - STAMP_W'(win_r);

  always_comb begin
    ctl.op = OP_HOLD;
    ctl.count = count_r;
    ctl.entry.stamp = req_r.stamp_ns;
    ctl.entry.pose = req_r.pose;
    ctl.stamp = (state_r == S_PRUNE) ? bound : req_r.stamp_ns;
    case (state_r)
      // full cache without an equal stamp: drop the oldest first
      S_FULL: if (count_r == CNT_W'(DEPTH) && !any_equal) ctl.op = OP_SHIFT_DOWN;
      S_INS: ctl.op = any_equal ? OP_REPLACE : OP_INSERT;
      S_PRUNE: if (n_below != '0) ctl.op = OP_SHIFT_DOWN;
      default: ;
    endcase
  end

  tpc_chain u_chain (
    .clk(clk), .ctl(ctl), .rd_idx(rd_idx_r), .n_below(n_below),
    .any_equal(any_equal), .rd_entry(rd_entry)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        if (in_data.command == CMD_LOOKUP) state_nxt = S_LK;
        else if (in_data.stamp_ns == '0) state_nxt = S_OUT;
        else state_nxt = S_FULL;
      end
      S_FULL: state_nxt = S_INS;
      S_INS: state_nxt = S_PRUNE;
      S_PRUNE: if (n_below == '0) state_nxt = S_OUT;
      S_LK: state_nxt = S_LK2;
      S_LK2: state_nxt = S_LK3;
      S_LK3: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      win_r <= WIN_RESET;
      gap_r <= GAP_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_WINDOW) win_r <= cfg_data[WIN_W-1:0];
        else gap_r <= cfg_data[GAP_W-1:0];
      end
      case (state_r)
        S_FULL:
          if (count_r == CNT_W'(DEPTH) && !any_equal) begin
            count_r <= count_r - 1'b1;
          end
        S_INS: if (!any_equal) count_r <= count_r + 1'b1;
        S_PRUNE: if (n_below != '0) count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) req_r <= in_data;
    if (state_r == S_LK) begin
      // upper neighbor is the first entry at or after the query
      have_up_r <= n_below < count_r;
      best_r <= n_below;
      rd_idx_r <= n_below;
    end
    if (state_r == S_LK2) begin
      rd_idx_r <= rd_idx_r - 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        out_r <= '{found: 1'b0, pose: '0, time_gap_ns: '0, entries_held: count_r};
      end
      S_PRUNE: out_r.entries_held <= (n_below != '0) ? count_r - 1'b1 : count_r;
      default: ;
    endcase
    if (state_r == S_LK3) begin
      out_r.entries_held <= count_r;
      if (req_r.stamp_ns == '0 || count_r == '0) begin
        out_r.time_gap_ns <= STAMP_ALL_ONES;
      end else begin
        out_r.time_gap_ns <= lk_gap;
        out_r.found <= lk_gap <= STAMP_W'(gap_r);
        out_r.pose <= (lk_gap <= STAMP_W'(gap_r)) ? lk_pose : '0;
      end
    end
  end

  // upper entry is read in S_LK2 and held; the lower one is on the port in S_LK3
  always_ff @(posedge clk) up_ent_r <= rd_entry;
  assign d_up = up_ent_r.stamp - req_r.stamp_ns;
  assign d_lo = req_r.stamp_ns - rd_entry.stamp;
  // tie goes to the later entry
  assign use_lo = (best_r != '0) && (!have_up_r || d_lo < d_up);
  assign lk_gap = use_lo ? d_lo : d_up;
  assign lk_pose = use_lo ? rd_entry.pose : up_ent_r.pose;

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (count_r <= CNT_W'(DEPTH)) else $error("count overflow");
    end
  end
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("two requests in work");
  a_prune: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRUNE && n_below != '0 |=> count_r == $past(count_r) - 1'b1)
    else $error("prune count");
endmodule

// ===== rtl/core/tpc_cell.sv =====
// One cache slot: holds an entry, compares to the broadcast stamp, shifts.
`timescale 1ns / 1ps
module tpc_cell import tpc_pkg::*; (
  input  logic               clk,
  input  logic [CNT_W-1:0]   idx,
  input  cell_ctl_t          ctl,
  input  entry_t             left_entry,
  input  logic               left_below,
  input  entry_t             right_entry,
  output entry_t             entry,
  output logic               below,
  output logic               equal
);
  entry_t entry_r;
  logic valid;

  assign entry = entry_r;
  assign valid = idx < ctl.count;
  assign below = valid && (entry_r.stamp < ctl.stamp);
  assign equal = valid && (entry_r.stamp == ctl.stamp);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        // first slot at or after the stamp takes the new entry; later ones move up
        if (!below && left_below) entry_r <= ctl.entry;
        else if (!below && idx != '0) entry_r <= left_entry;
        else if (!below) entry_r <= ctl.entry;
      end
      OP_REPLACE: if (equal) entry_r <= ctl.entry;
      OP_SHIFT_DOWN: entry_r <= right_entry;
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/tpc_chain.sv =====
// Row of cells plus first-not-below and equal reductions over the row.
`timescale 1ns / 1ps
module tpc_chain import tpc_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] rd_idx,
  output logic [CNT_W-1:0] n_below,
  output logic             any_equal,
  output entry_t           rd_entry
);
  entry_t ent [DEPTH];
  logic [DEPTH-1:0] blw, eqv;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t le, re;
    logic lb;
    if (i == 0) begin : g_l
      assign le = ctl.entry;
      assign lb = 1'b0;
    end else begin : g_l
      assign le = ent[i-1];
      assign lb = blw[i-1];
    end
    if (i == DEPTH - 1) begin : g_r
      assign re = ent[i];
    end else begin : g_r
      assign re = ent[i+1];
    end
    tpc_cell u_cell (
      .clk(clk), .idx(CNT_W'(i)), .ctl(ctl), .left_entry(le), .left_below(lb),
      .right_entry(re), .entry(ent[i]), .below(blw[i]), .equal(eqv[i])
    );
  end

  // entries are sorted, so the below flags form a prefix
  assign n_below = CNT_W'($countones(blw));
  assign any_equal = |eqv;
  assign rd_entry = ent[rd_idx[$clog2(DEPTH)-1:0]];
endmodule
